// ===== rtl/price_return_risk_stats_macros.svh =====
// Assertion macros shared by the price return risk statistics RTL.
// Depends on nothing; include by bare file name inside a module body.
`ifndef PRICE_RETURN_RISK_STATS_MACROS_SVH
`define PRICE_RETURN_RISK_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRRS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prrs_pkg.sv =====
// Shared types and constants for the price return risk statistics block.
// No dependencies; every RTL module but prrs_ram imports it.
`default_nettype none

package prrs_pkg;

    localparam int PRICE_W     = 32;
    localparam int MAX_RETURNS = 4096;
    localparam int ADDR_W      = $clog2(MAX_RETURNS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int ROWCNT_W    = 13;
    localparam int TROW_W      = 12;
    localparam int PPY_W       = 16;
    localparam int SUM_W       = 44;
    localparam int DIV_W       = 64;
    localparam int DD_W        = 31;
    localparam int RET_W       = 32;
    localparam int ROOT_W      = 41;
    localparam int SREM_W      = 44;
    localparam int SQRT_STEPS  = 40;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = 4;

    localparam logic [PPY_W-1:0]    PPY_RESET = 16'd252;
    localparam logic [ROWCNT_W-1:0] ROW_MAX   = 13'd8191;
    localparam logic [TROW_W-1:0]   TROW_MAX  = 12'd4095;

    // Error flag bit positions
    localparam int FLAG_ZERO = 0;
    localparam int FLAG_SAT  = 1;
    localparam int FLAG_OVF  = 2;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_NO_RET     = 3'd1,
        STAT_ONE_RET    = 3'd2,
        STAT_ZERO_PRICE = 3'd3,
        STAT_SAT        = 3'd4,
        STAT_OVF        = 3'd5
    } status_t;

    typedef struct packed {
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] close_price;
        logic               open_present;
        logic               close_present;
        logic               last_row;
    } row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_FINAL,
        ST_MEAN,
        ST_VRD,
        ST_VDAT,
        ST_VMUL,
        ST_VACC,
        ST_VDIV,
        ST_VWAIT,
        ST_VSCALE,
        ST_SQRT,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/prrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module prrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ===== rtl/prrs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on prrs_pkg.
`default_nettype none

module prrs_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [prrs_pkg::DIV_W-1:0]    dividend,
    input  wire logic [prrs_pkg::PRICE_W-1:0]  divisor,
    output logic                               busy,
    output logic      [prrs_pkg::DIV_W-1:0]    quot
);
    import prrs_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic               busy_reg, busy_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]   q_reg, q_next;
    logic [PRICE_W-1:0] r_reg, r_next;
    logic [PRICE_W-1:0] d_reg, d_next;
    logic [PRICE_W:0]   rem_sh;
    logic [PRICE_W:0]   rem_sub;
    logic               ge;

    always_comb begin
        rem_sh    = {r_reg, q_reg[DIV_W-1]};
        rem_sub   = rem_sh - {1'b0, d_reg};
        ge        = rem_sh >= {1'b0, d_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next   = {q_reg[DIV_W-2:0], ge};
            r_next   = ge ? rem_sub[PRICE_W-1:0] : rem_sh[PRICE_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

`default_nettype wire

// ===== rtl/prrs_front.sv =====
// Input side: accepts price rows and holds them in a two-entry queue.
// Depends on prrs_pkg.
`default_nettype none

module prrs_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [prrs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [prrs_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                            s_tlast,
    input  wire logic                            pop,
    output logic                                 q_valid,
    output prrs_pkg::row_t                       q_row
);
    import prrs_pkg::*;

    row_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    row_t       in_row;

    always_comb begin
        in_row.open_price    = s_tdata[PRICE_W-1:0];
        in_row.close_price   = s_tdata[2*PRICE_W-1:PRICE_W];
        in_row.open_present  = s_tuser[0];
        in_row.close_present = s_tuser[1];
        in_row.last_row      = s_tlast;
        s_tready    = cnt_reg != 2'd2;
        push        = s_tvalid && s_tready;
        q_valid     = cnt_reg != 2'd0;
        q_row       = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_row;
        end
    end
endmodule

`default_nettype wire

// ===== rtl/prrs_back.sv =====
// Back end: per-row return and drawdown, final statistics pass and result register.
// Depends on prrs_pkg, prrs_div, prrs_ram and the assertion macro header.
`default_nettype none

module prrs_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    input  wire prrs_pkg::row_t                  q_row,
    output logic                                 pop,
    input  wire logic [prrs_pkg::PPY_W-1:0]      ppy,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [prrs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic      [prrs_pkg::M_TUSER_W-1:0]  m_tuser
);
    import prrs_pkg::*;
    `include "price_return_risk_stats_macros.svh"

    back_state_t          state_reg, state_next;
    row_t                 row_reg, row_next;
    logic [PRICE_W-1:0]   prev_reg, prev_next;
    logic                 prev_ok_reg, prev_ok_next;
    logic [PRICE_W-1:0]   peak_reg, peak_next;
    logic [DD_W-1:0]      worst_reg, worst_next;
    logic [TROW_W-1:0]    wrow_reg, wrow_next;
    logic                 found_reg, found_next;
    logic [ROWCNT_W-1:0]  rcnt_reg, rcnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     stored_reg, stored_next;
    logic [2:0]           flags_reg, flags_next;
    logic                 dd_run_reg, dd_run_next;
    logic                 ret_run_reg, ret_run_next;
    logic                 neg_reg, neg_next;
    logic [RET_W-1:0]     mean_reg, mean_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [RET_W-1:0]     mag_reg, mag_next;
    logic [DIV_W-1:0]     sq_reg, sq_next;
    logic [DIV_W-1:0]     acc_reg, acc_next;
    logic [DIV_W-1:0]     prod_reg, prod_next;
    logic [DIV_W+15:0]    x_reg, x_next;
    logic [SREM_W-1:0]    srem_reg, srem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [5:0]           scnt_reg, scnt_next;
    logic [RET_W-1:0]     vol_reg, vol_next;
    logic                 mv_reg, mv_next;
    logic [M_TDATA_W-1:0] md_reg, md_next;
    logic [M_TUSER_W-1:0] mu_reg, mu_next;

    logic                 dd_start, ret_start, dd_busy, ret_busy;
    logic [DIV_W-1:0]     dd_dvd, ret_dvd, dd_q, ret_q;
    logic [PRICE_W-1:0]   dd_dvs, ret_dvs;
    logic                 ram_we;
    logic [RET_W-1:0]     ram_wdata, ram_rdata;

    logic [PRICE_W-1:0]   peak_new, diff;
    logic [RET_W-1:0]     r_val;
    logic [SUM_W-1:0]     sum_abs;
    logic [RET_W+1:0]     dlt, dlt_abs;
    logic [DIV_W+PPY_W-1:0] prod_full;
    logic [SREM_W-1:0]    rem_sh, trial;
    logic [ROOT_W-1:0]    root_new;
    status_t              stat;

    prrs_div u_div_dd (
        .aclk, .aresetn, .start(dd_start), .dividend(dd_dvd), .divisor(dd_dvs),
        .busy(dd_busy), .quot(dd_q)
    );

    prrs_div u_div_ret (
        .aclk, .aresetn, .start(ret_start), .dividend(ret_dvd), .divisor(ret_dvs),
        .busy(ret_busy), .quot(ret_q)
    );

    prrs_ram #(.WIDTH(RET_W), .DEPTH(MAX_RETURNS)) u_store (
        .aclk, .we(ram_we), .waddr(stored_reg[ADDR_W-1:0]), .wdata(ram_wdata),
        .raddr(idx_reg[ADDR_W-1:0]), .rdata(ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        prev_next    = prev_reg;
        prev_ok_next = prev_ok_reg;
        peak_next    = peak_reg;
        worst_next   = worst_reg;
        wrow_next    = wrow_reg;
        found_next   = found_reg;
        rcnt_next    = rcnt_reg;
        sum_next     = sum_reg;
        stored_next  = stored_reg;
        flags_next   = flags_reg;
        dd_run_next  = dd_run_reg;
        ret_run_next = ret_run_reg;
        neg_next     = neg_reg;
        mean_next    = mean_reg;
        idx_next     = idx_reg;
        mag_next     = mag_reg;
        sq_next      = sq_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        x_next       = x_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        scnt_next    = scnt_reg;
        vol_next     = vol_reg;
        md_next      = md_reg;
        mu_next      = mu_reg;
        mv_next      = mv_reg && !m_tready;
        pop          = 1'b0;
        dd_start     = 1'b0;
        ret_start    = 1'b0;
        dd_dvd       = '0;
        dd_dvs       = '0;
        ret_dvd      = '0;
        ret_dvs      = '0;
        ram_we       = 1'b0;

        peak_new = (q_row.close_present && q_row.close_price > peak_reg)
                   ? q_row.close_price : peak_reg;
        diff = (q_row.open_price < prev_reg) ? prev_reg - q_row.open_price
                                             : q_row.open_price - prev_reg;
        r_val = ret_q[RET_W-1:0];
        if (!neg_reg && ret_q[DIV_W-1:RET_W-1] != '0) begin
            r_val = {1'b0, {(RET_W-1){1'b1}}};
        end else if (neg_reg) begin
            r_val = -ret_q[RET_W-1:0];
        end
        ram_wdata = r_val;
        sum_abs   = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
        dlt       = {{2{ram_rdata[RET_W-1]}}, ram_rdata} - {{2{mean_reg[RET_W-1]}}, mean_reg};
        dlt_abs   = dlt[RET_W+1] ? -dlt : dlt;
        prod_full = ret_q * ppy;
        rem_sh    = {srem_reg[SREM_W-3:0], x_reg[DIV_W+15:DIV_W+14]};
        trial     = {1'b0, root_reg, 2'b01};
        root_new  = (rem_sh >= trial) ? {root_reg[ROOT_W-2:0], 1'b1}
                                      : {root_reg[ROOT_W-2:0], 1'b0};

        if (stored_reg == CNT_W'(0)) begin
            stat = STAT_NO_RET;
        end else if (stored_reg == CNT_W'(1)) begin
            stat = STAT_ONE_RET;
        end else if (flags_reg[FLAG_OVF]) begin
            stat = STAT_OVF;
        end else if (flags_reg[FLAG_SAT]) begin
            stat = STAT_SAT;
        end else if (flags_reg[FLAG_ZERO]) begin
            stat = STAT_ZERO_PRICE;
        end else begin
            stat = STAT_OK;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop       = 1'b1;
                    row_next  = q_row;
                    peak_next = peak_new;
                    // Launch drawdown and return divisions side by side.
                    dd_start    = q_row.close_present && peak_new != '0;
                    dd_dvd      = {2'b00, peak_new - q_row.close_price, 30'd0};
                    dd_dvs      = peak_new;
                    dd_run_next = dd_start;
                    ret_start    = q_row.open_present && prev_ok_reg && prev_reg != '0;
                    ret_dvd      = {2'b00, diff, 30'd0};
                    ret_dvs      = prev_reg;
                    ret_run_next = ret_start;
                    neg_next     = q_row.open_price < prev_reg;
                    state_next   = ST_ROW;
                end
            end
            ST_ROW: begin
                if (!dd_busy && !ret_busy) begin
                    if (row_reg.close_present) begin
                        if (dd_run_reg && dd_q[DD_W-1:0] > worst_reg) begin
                            worst_next = dd_q[DD_W-1:0];
                            wrow_next  = (rcnt_reg > ROWCNT_W'(TROW_MAX)) ? TROW_MAX
                                                                        : rcnt_reg[TROW_W-1:0];
                            found_next = 1'b1;
                        end
                    end else if (rcnt_reg == '0) begin
                        flags_next[FLAG_ZERO] = 1'b1;
                    end
                    if (row_reg.open_present && prev_ok_reg) begin
                        if (!ret_run_reg) begin
                            flags_next[FLAG_ZERO] = 1'b1;
                        end else begin
                            if (!neg_reg && ret_q[DIV_W-1:RET_W-1] != '0) begin
                                flags_next[FLAG_SAT] = 1'b1;
                            end
                            if (stored_reg < CNT_W'(MAX_RETURNS)) begin
                                ram_we      = 1'b1;
                                stored_next = stored_reg + 1'b1;
                                sum_next    = sum_reg + {{(SUM_W-RET_W){r_val[RET_W-1]}}, r_val};
                            end else begin
                                flags_next[FLAG_OVF] = 1'b1;
                            end
                        end
                    end
                    prev_next    = row_reg.close_price;
                    prev_ok_next = row_reg.close_present;
                    if (rcnt_reg < ROW_MAX) begin
                        rcnt_next = rcnt_reg + 1'b1;
                    end
                    state_next = row_reg.last_row ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (stored_reg == '0) begin
                    mean_next  = '0;
                    vol_next   = '0;
                    state_next = ST_OUT;
                end else begin
                    ret_start  = 1'b1;
                    ret_dvd    = {{(DIV_W-SUM_W){1'b0}}, sum_abs};
                    ret_dvs    = {{(PRICE_W-CNT_W){1'b0}}, stored_reg};
                    neg_next   = sum_reg[SUM_W-1];
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (!ret_busy) begin
                    mean_next = neg_reg ? -ret_q[RET_W-1:0] : ret_q[RET_W-1:0];
                    idx_next  = '0;
                    acc_next  = '0;
                    vol_next  = '0;
                    state_next = (stored_reg == CNT_W'(1)) ? ST_OUT : ST_VRD;
                end
            end
            ST_VRD: state_next = ST_VDAT;
            ST_VDAT: begin
                mag_next   = dlt_abs[RET_W-1:0];
                state_next = ST_VMUL;
            end
            ST_VMUL: begin
                sq_next    = {32'd0, mag_reg} * {32'd0, mag_reg};
                state_next = ST_VACC;
            end
            ST_VACC: begin
                acc_next   = acc_reg + {16'd0, sq_reg[DIV_W-1:16]};
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == stored_reg) ? ST_VDIV : ST_VRD;
            end
            ST_VDIV: begin
                ret_start  = 1'b1;
                ret_dvd    = acc_reg;
                ret_dvs    = {{(PRICE_W-CNT_W){1'b0}}, stored_reg - 1'b1};
                state_next = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (!ret_busy) begin
                    prod_next  = prod_full[DIV_W-1:0];
                    state_next = ST_VSCALE;
                end
            end
            ST_VSCALE: begin
                x_next     = {prod_reg, 16'd0};
                srem_next  = '0;
                root_next  = '0;
                scnt_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                srem_next = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
                root_next = root_new;
                x_next    = {x_reg[DIV_W+13:0], 2'b00};
                scnt_next = scnt_reg + 1'b1;
                if (scnt_reg == 6'(SQRT_STEPS - 1)) begin
                    vol_next   = (root_new[ROOT_W-1:RET_W] != '0) ? '1 : root_new[RET_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    md_next = {1'b0,
                               (stored_reg > CNT_W'(TROW_MAX)) ? TROW_MAX
                                                               : stored_reg[TROW_W-1:0],
                               wrow_reg, worst_reg, vol_reg, mean_reg};
                    mu_next = {stat, found_reg};
                    // Clear the per-set state; the register value stays.
                    prev_next    = '0;
                    prev_ok_next = 1'b0;
                    peak_next    = '0;
                    worst_next   = '0;
                    wrow_next    = '0;
                    found_next   = 1'b0;
                    rcnt_next    = '0;
                    sum_next     = '0;
                    stored_next  = '0;
                    flags_next   = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_reg    <= '0;
            prev_ok_reg <= 1'b0;
            peak_reg    <= '0;
            worst_reg   <= '0;
            wrow_reg    <= '0;
            found_reg   <= 1'b0;
            rcnt_reg    <= '0;
            sum_reg     <= '0;
            stored_reg  <= '0;
            flags_reg   <= '0;
            mv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            prev_ok_reg <= prev_ok_next;
            peak_reg    <= peak_next;
            worst_reg   <= worst_next;
            wrow_reg    <= wrow_next;
            found_reg   <= found_next;
            rcnt_reg    <= rcnt_next;
            sum_reg     <= sum_next;
            stored_reg  <= stored_next;
            flags_reg   <= flags_next;
            mv_reg      <= mv_next;
        end
        row_reg     <= row_next;
        dd_run_reg  <= dd_run_next;
        ret_run_reg <= ret_run_next;
        neg_reg     <= neg_next;
        mean_reg    <= mean_next;
        idx_reg     <= idx_next;
        mag_reg     <= mag_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        x_reg       <= x_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        scnt_reg    <= scnt_next;
        vol_reg     <= vol_next;
        md_reg      <= md_next;
        mu_reg      <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    `PRRS_ASSERT_NOW(a_pop_idle, aclk, aresetn, pop, state_reg == ST_IDLE && q_valid, "pop outside idle")
    `PRRS_ASSERT_NOW(a_store_room, aclk, aresetn, ram_we, stored_reg < CNT_W'(MAX_RETURNS), "store write past end")
    `PRRS_ASSERT_NOW(a_div_free, aclk, aresetn, ret_start || dd_start, !ret_busy && !dd_busy, "divider restarted while busy")
    `PRRS_ASSERT_NEXT(a_clear_after_out, aclk, aresetn, state_reg == ST_OUT && state_next == ST_IDLE, stored_reg == '0 && mv_reg, "state not cleared after result")
endmodule

`default_nettype wire

// ===== rtl/price_return_risk_stats.sv =====
// Top level of the price return risk statistics block: ports, register, front/back.
// Depends on prrs_pkg, prrs_front and prrs_back.
`default_nettype none

// Return statistics and maximum drawdown over a stream of price rows. Each
// request on the s_ channel is one row (Q16.16 open and close with presence
// flags, tlast on the final row). A two-entry queue takes rows in while the
// back end works; it handles one row at a time with the 64-step restoring
// dividers that form the return and drawdown in parallel. On the last row
// it runs a mean division if any return is stored and, with two or more, a
// pass over the stored returns one at a time through the store's single
// read port, a variance division, a scale and a 40-step square root, and
// places one result in the m_ output register, held until taken. The user
// writes the periods_per_year register (reset 252) through cfg_valid/cfg_ready
// only while the block is idle, unenforced by the block; cfg_ready stays high.
module price_return_risk_stats (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [31:0] open_price, [63:32] close_price
    input  wire logic [prrs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] open_present, [1] close_present
    input  wire logic [prrs_pkg::S_TUSER_W-1:0]  s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] mean_return, [63:32] annual_volatility, [94:64] drawdown,
    // [106:95] trough_row, [118:107] return_count, [119] zero
    output logic      [prrs_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] trough_valid, [3:1] status
    output logic      [prrs_pkg::M_TUSER_W-1:0]  m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [prrs_pkg::PPY_W-1:0]      cfg_data
);
    import prrs_pkg::*;

    logic [PPY_W-1:0] ppy_reg, ppy_next;
    logic             q_valid, pop;
    row_t             q_row;

    // Hold the annualisation factor; a write is registered into ppy_reg.
    assign cfg_ready = 1'b1;
    assign ppy_next  = (cfg_valid && cfg_ready) ? cfg_data : ppy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppy_reg <= PPY_RESET;
        end else begin
            ppy_reg <= ppy_next;
        end
    end

    prrs_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .pop, .q_valid, .q_row
    );

    prrs_back u_back (
        .aclk, .aresetn, .q_valid, .q_row, .pop, .ppy(ppy_reg),
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );
endmodule

`default_nettype wire
